FILE: rtl/core/tcls_pkg.sv
// Package for the tiled copy layout search block.
// Holds controller states, command and status structs, sizing constants and the atom table.
// No dependencies.
`default_nettype none
package tcls_pkg;

    localparam int EXTENT_MAX = 65535;
    localparam int EXT_W      = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_VF_START,
        ST_TN_CHECK,
        ST_DIV_Q,
        ST_DIV_VM,
        ST_VM_CHECK,
        ST_DIV_MOD,
        ST_UPDATE,
        ST_TN_NEXT,
        ST_VF_END,
        ST_VF_NEXT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_SEL_Q,
        DIV_SEL_VM,
        DIV_SEL_MOD
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     vf_init;
        logic     vf_dec;
        logic     tn_init;
        logic     tn_inc;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_q;
        logic     take_vm;
        logic     vm_half;
        logic     update;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic invalid;
        logic cols_vf_ok;
        logic tn_in_range;
        logic tn_ok;
        logic skip;
        logic div_done;
        logic vm_gt1;
        logic rem_nz;
        logic have;
        logic vf_is1;
        logic out_free;
    } status_t;

    localparam logic [2:0] ATOM_ASYNC_128 = 3'd0;
    localparam logic [2:0] ATOM_ASYNC_64  = 3'd1;
    localparam logic [2:0] ATOM_ASYNC_32  = 3'd2;
    localparam logic [2:0] ATOM_VEC_128   = 3'd3;
    localparam logic [2:0] ATOM_VEC_64    = 3'd4;
    localparam logic [2:0] ATOM_VEC_32    = 3'd5;
    localparam logic [2:0] ATOM_VEC_16    = 3'd6;
    localparam logic [2:0] ATOM_UNIVERSAL = 3'd7;

    // align_log is log2 of the alignment in bits
    function automatic logic [2:0] atom_for(input logic [3:0] align_log, input logic async_ok);
        logic [2:0] code;
        begin
            code = ATOM_UNIVERSAL;
            case (align_log)
                4'd7:    code = async_ok ? ATOM_ASYNC_128 : ATOM_VEC_128;
                4'd6:    code = async_ok ? ATOM_ASYNC_64 : ATOM_VEC_64;
                4'd5:    code = async_ok ? ATOM_ASYNC_32 : ATOM_VEC_32;
                4'd4:    code = ATOM_VEC_16;
                default: code = ATOM_UNIVERSAL;
            endcase
            return code;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tcls_if.sv
// Request and result channel interfaces for the tiled copy layout search block.
// No dependencies.
`default_nettype none
interface tcls_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] box_rows;
    logic [15:0] box_cols;
    logic [15:0] thread_count;
    logic [1:0]  elem_size_code;
    logic        to_shared;
    modport source (output valid, box_rows, box_cols, thread_count, elem_size_code, to_shared,
                    input ready);
    modport sink (input valid, box_rows, box_cols, thread_count, elem_size_code, to_shared,
                  output ready);
endinterface

interface tcls_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] thread_rows;
    logic [15:0] thread_cols;
    logic [4:0]  value_rows;
    logic [15:0] value_cols;
    logic [2:0]  atom_code;
    logic        need_predicate;
    logic [15:0] pred_rows;
    logic [15:0] pred_cols;
    modport source (output valid, found, thread_rows, thread_cols, value_rows, value_cols,
                    atom_code, need_predicate, pred_rows, pred_cols, input ready);
    modport sink (input valid, found, thread_rows, thread_cols, value_rows, value_cols,
                  atom_code, need_predicate, pred_rows, pred_cols, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tiled_copy_layout_search_top.sv
// A rejected request goes straight to the result register. A search takes each thread-column
// candidate that passes its checks through a row division, a value-row division and the
// value-row trials, drops a padded candidate after the row division when an unpadded one is
// held, and skips columns and factors that fail their checks. One item at a time; one divider.
// A new item is taken once the previous result is in the output register.
// Reset: asynchronous, active low; clears controller state and the result valid flag.
`default_nettype none
module tiled_copy_layout_search_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcls_req_if.sink   req,
    tcls_rsp_if.source rsp
);
    tcls_pkg::cmd_t    cmd;
    tcls_pkg::status_t st;
    logic              rdy;

    assign req.ready = rdy;

    tcls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (rdy),
        .st       (st),
        .cmd      (cmd)
    );

    tcls_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .st    (st),
        .req   (req),
        .rsp   (rsp)
    );
endmodule
`default_nettype wire

FILE: rtl/core/tcls_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit operands.
// No dependencies.
`default_nettype none
module tcls_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [15:0]      quot,
    output logic [15:0]      rem
);
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quot_reg, quot_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] partial;
    logic        ge;

    always_comb
    begin
        partial   = {rem_reg, quot_reg[15]};
        ge        = partial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? 16'(partial - {1'b0, dvs_reg}) : partial[15:0];
            quot_next = {quot_reg[14:0], ge};
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

FILE: rtl/core/tcls_datapath.sv
// Datapath: request registers, search counters, best candidate and result register.
// Depends on tcls_pkg, tcls_if and tcls_div.
`default_nettype none
module tcls_datapath (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tcls_pkg::cmd_t cmd,
    output tcls_pkg::status_t st,
    tcls_req_if.sink        req,
    tcls_rsp_if.source      rsp
);
    logic [15:0] rows_reg, cols_reg, thr_reg;
    logic [1:0]  esc_reg;
    logic        g2s_reg;
    logic [2:0]  vf_log_reg, vf_log_next;
    logic [4:0]  tn_log_reg, tn_log_next;
    logic [15:0] q_reg;
    logic        pred_reg;
    logic [4:0]  vm_reg;
    logic [15:0] b_tm_reg, b_tn_reg, b_vn_reg;
    logic [4:0]  b_vm_reg;
    logic        b_pred_reg;
    logic        have_reg, have_next;
    logic        out_valid_reg;
    logic        o_found_reg, o_pred_reg;
    logic [15:0] o_tm_reg, o_tn_reg, o_vn_reg, o_prows_reg, o_pcols_reg;
    logic [4:0]  o_vm_reg;
    logic [2:0]  o_atom_reg;

    logic [16:0] tn;
    logic [15:0] tm, vn;
    logic [4:0]  vf, max_vf;
    logic [5:0]  span_log;
    logic [20:0] span;
    logic [15:0] div_a, div_b, div_q, div_r;
    logic        div_done;
    logic [3:0]  align_log;
    logic        async_ok;

    assign tn       = 17'(1) << tn_log_reg;
    assign tm       = thr_reg >> tn_log_reg;
    assign vn       = cols_reg >> tn_log_reg;
    assign vf       = 5'(1) << vf_log_reg;
    assign max_vf   = 5'(1) << (3'd4 - {1'b0, esc_reg});
    assign span_log = 6'(tn_log_reg) + 6'(vf_log_reg);
    assign span     = 21'(1) << span_log;
    assign align_log = 4'(vf_log_reg) + 4'd3 + 4'(esc_reg);
    assign async_ok = g2s_reg && (thr_reg[4:0] == 5'd0);

    always_comb
    begin
        case (cmd.div_sel)
            tcls_pkg::DIV_SEL_Q:
            begin
                div_a = rows_reg;
                div_b = tm;
            end
            tcls_pkg::DIV_SEL_VM:
            begin
                div_a = 16'(max_vf);
                div_b = vn;
            end
            tcls_pkg::DIV_SEL_MOD:
            begin
                div_a = q_reg;
                div_b = 16'(vm_reg);
            end
            default:
            begin
                div_a = rows_reg;
                div_b = tm;
            end
        endcase
    end

    tcls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        st.invalid     = (rows_reg == 16'd0) || (cols_reg == 16'd0) || (thr_reg < 16'd2)
                         || (32'(rows_reg) > tcls_pkg::EXTENT_MAX)
                         || (32'(cols_reg) > tcls_pkg::EXTENT_MAX);
        st.cols_vf_ok  = (cols_reg & 16'(vf - 5'd1)) == 16'd0;
        st.tn_in_range = (tn <= {1'b0, thr_reg}) && (span <= {5'd0, cols_reg});
        st.tn_ok       = ((17'(thr_reg) & (tn - 17'd1)) == 17'd0)
                         && ((17'(cols_reg) & (tn - 17'd1)) == 17'd0)
                         && ((vn & 16'(vf - 5'd1)) == 16'd0);
        st.skip        = (div_r != 16'd0) && have_reg && !b_pred_reg;
        st.div_done    = div_done;
        st.vm_gt1      = vm_reg > 5'd1;
        st.rem_nz      = div_r != 16'd0;
        st.have        = have_reg;
        st.vf_is1      = vf_log_reg == 3'd0;
        st.out_free    = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        vf_log_next = vf_log_reg;
        tn_log_next = tn_log_reg;
        have_next   = have_reg;
        if (cmd.load)
            have_next = 1'b0;
        if (cmd.vf_init)
            vf_log_next = 3'd4 - {1'b0, esc_reg};
        if (cmd.vf_dec)
            vf_log_next = vf_log_reg - 3'd1;
        if (cmd.tn_init)
        begin
            tn_log_next = '0;
            have_next   = 1'b0;
        end
        if (cmd.tn_inc)
            tn_log_next = tn_log_reg + 5'd1;
        if (cmd.update)
            have_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_log_reg    <= '0;
            tn_log_reg    <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vf_log_reg <= vf_log_next;
            tn_log_reg <= tn_log_next;
            have_reg   <= have_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rows_reg <= req.box_rows;
            cols_reg <= req.box_cols;
            thr_reg  <= req.thread_count;
            esc_reg  <= req.elem_size_code;
            g2s_reg  <= req.to_shared;
        end
        if (cmd.take_q)
        begin
            pred_reg <= div_r != 16'd0;
            q_reg    <= div_q + 16'(div_r != 16'd0);
        end
        if (cmd.take_vm)
            vm_reg <= (div_q[15:5] == 11'd0 && div_q[4:0] != 5'd0) ? div_q[4:0] : 5'd1;
        else if (cmd.vm_half)
            vm_reg <= vm_reg >> 1;
        if (cmd.update)
        begin
            b_tm_reg   <= tm;
            b_tn_reg   <= tn[15:0];
            b_vm_reg   <= vm_reg;
            b_vn_reg   <= vn;
            b_pred_reg <= pred_reg;
        end
        if (cmd.out_load)
        begin
            o_found_reg <= have_reg;
            o_tm_reg    <= have_reg ? b_tm_reg : 16'd0;
            o_tn_reg    <= have_reg ? b_tn_reg : 16'd0;
            o_vm_reg    <= have_reg ? b_vm_reg : 5'd0;
            o_vn_reg    <= have_reg ? b_vn_reg : 16'd0;
            o_atom_reg  <= have_reg ? tcls_pkg::atom_for(align_log, async_ok) : 3'd0;
            o_pred_reg  <= have_reg && b_pred_reg;
            o_prows_reg <= (have_reg && b_pred_reg) ? rows_reg : 16'd0;
            o_pcols_reg <= (have_reg && b_pred_reg) ? cols_reg : 16'd0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.found          = o_found_reg;
    assign rsp.thread_rows    = o_tm_reg;
    assign rsp.thread_cols    = o_tn_reg;
    assign rsp.value_rows     = o_vm_reg;
    assign rsp.value_cols     = o_vn_reg;
    assign rsp.atom_code      = o_atom_reg;
    assign rsp.need_predicate = o_pred_reg;
    assign rsp.pred_rows      = o_prows_reg;
    assign rsp.pred_cols      = o_pcols_reg;
endmodule
`default_nettype wire

FILE: rtl/core/tcls_ctrl.sv
// Controller for the layout search: walks vector factors, thread columns and value rows.
// Depends on tcls_pkg.
`default_nettype none
module tcls_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tcls_pkg::status_t st,
    output tcls_pkg::cmd_t     cmd
);
    tcls_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tcls_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = tcls_pkg::DIV_SEL_Q;
        in_ready    = 1'b0;
        case (state_reg)
            tcls_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tcls_pkg::ST_CHECK;
                end
            end
            tcls_pkg::ST_CHECK:
            begin
                if (st.invalid)
                    state_next = tcls_pkg::ST_DONE;
                else
                begin
                    cmd.vf_init = 1'b1;
                    state_next  = tcls_pkg::ST_VF_START;
                end
            end
            tcls_pkg::ST_VF_START:
            begin
                cmd.tn_init = 1'b1;
                state_next  = st.cols_vf_ok ? tcls_pkg::ST_TN_CHECK : tcls_pkg::ST_VF_NEXT;
            end
            tcls_pkg::ST_TN_CHECK:
            begin
                if (!st.tn_in_range)
                    state_next = tcls_pkg::ST_VF_END;
                else if (!st.tn_ok)
                    state_next = tcls_pkg::ST_TN_NEXT;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = tcls_pkg::DIV_SEL_Q;
                    state_next    = tcls_pkg::ST_DIV_Q;
                end
            end
            tcls_pkg::ST_DIV_Q:
            begin
                if (st.div_done)
                begin
                    cmd.take_q = 1'b1;
                    if (st.skip)
                        state_next = tcls_pkg::ST_TN_NEXT;
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = tcls_pkg::DIV_SEL_VM;
                        state_next    = tcls_pkg::ST_DIV_VM;
                    end
                end
            end
            tcls_pkg::ST_DIV_VM:
            begin
                cmd.div_sel = tcls_pkg::DIV_SEL_VM;
                if (st.div_done)
                begin
                    cmd.take_vm = 1'b1;
                    state_next  = tcls_pkg::ST_VM_CHECK;
                end
            end
            tcls_pkg::ST_VM_CHECK:
            begin
                if (st.vm_gt1)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = tcls_pkg::DIV_SEL_MOD;
                    state_next    = tcls_pkg::ST_DIV_MOD;
                end
                else
                    state_next = tcls_pkg::ST_UPDATE;
            end
            tcls_pkg::ST_DIV_MOD:
            begin
                cmd.div_sel = tcls_pkg::DIV_SEL_MOD;
                if (st.div_done)
                begin
                    if (st.rem_nz)
                    begin
                        cmd.vm_half = 1'b1;
                        state_next  = tcls_pkg::ST_VM_CHECK;
                    end
                    else
                        state_next = tcls_pkg::ST_UPDATE;
                end
            end
            tcls_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = tcls_pkg::ST_TN_NEXT;
            end
            tcls_pkg::ST_TN_NEXT:
            begin
                cmd.tn_inc = 1'b1;
                state_next = tcls_pkg::ST_TN_CHECK;
            end
            tcls_pkg::ST_VF_END:
                state_next = st.have ? tcls_pkg::ST_DONE : tcls_pkg::ST_VF_NEXT;
            tcls_pkg::ST_VF_NEXT:
            begin
                if (st.vf_is1)
                    state_next = tcls_pkg::ST_DONE;
                else
                begin
                    cmd.vf_dec = 1'b1;
                    state_next = tcls_pkg::ST_VF_START;
                end
            end
            tcls_pkg::ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tcls_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tcls_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/core/tcls_check.sv
// Port-level checks for the tiled copy layout search block, bound to the top level.
// Depends on tiled_copy_layout_search_top and its channel interfaces.
`default_nettype none
module tcls_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic        found,
    input wire logic [15:0] thread_rows,
    input wire logic [15:0] thread_cols,
    input wire logic [4:0]  value_rows,
    input wire logic [15:0] value_cols,
    input wire logic [2:0]  atom_code,
    input wire logic        need_predicate,
    input wire logic [15:0] pred_rows,
    input wire logic [15:0] pred_cols
);
    a_empty_plan: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !found |-> thread_rows == 16'd0 && thread_cols == 16'd0
            && value_rows == 5'd0 && value_cols == 16'd0 && atom_code == 3'd0
            && !need_predicate)
        else $error("empty plan carries data");

    a_cols_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        valid && found |-> $onehot(thread_cols) && thread_rows != 16'd0 && value_rows != 5'd0)
        else $error("bad thread layout");

    a_pred_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !need_predicate |-> pred_rows == 16'd0 && pred_cols == 16'd0)
        else $error("predicate bounds without predication");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(thread_rows) && $stable(value_cols))
        else $error("stalled item changed");
endmodule

bind tiled_copy_layout_search_top tcls_check u_tcls_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (rsp.valid),
    .ready          (rsp.ready),
    .found          (rsp.found),
    .thread_rows    (rsp.thread_rows),
    .thread_cols    (rsp.thread_cols),
    .value_rows     (rsp.value_rows),
    .value_cols     (rsp.value_cols),
    .atom_code      (rsp.atom_code),
    .need_predicate (rsp.need_predicate),
    .pred_rows      (rsp.pred_rows),
    .pred_cols      (rsp.pred_cols)
);
`default_nettype wire

FILE: sim/tcls_tb_if.sv
// Testbench side of the channel interfaces: they are shared with the RTL.
// Holds no declarations of its own; depends on rtl/core/tcls_if.sv.
`timescale 1ns / 1ps

FILE: sim/tiled_copy_layout_search_top_test.sv
// Testbench for the tiled copy layout search block: directed table, then random requests,
// each result checked against a behavioural planner. Depends on tcls_pkg and tcls_if.
`timescale 1ns / 1ps
`default_nettype none
module tiled_copy_layout_search_top_test;

    typedef struct packed {
        logic [15:0] box_rows;
        logic [15:0] box_cols;
        logic [15:0] thread_count;
        logic [1:0]  elem_size_code;
        logic        to_shared;
    } plan_req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] thread_rows;
        logic [15:0] thread_cols;
        logic [4:0]  value_rows;
        logic [15:0] value_cols;
        logic [2:0]  atom_code;
        logic        need_predicate;
        logic [15:0] pred_rows;
        logic [15:0] pred_cols;
    } plan_t;

    typedef struct {
        plan_req_t r;
        logic      has_plan;
        plan_t     p;
    } row_t;

    logic clk;
    logic rst_n;
    tcls_req_if req ();
    tcls_rsp_if rsp ();

    tiled_copy_layout_search_top DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    plan_t plan_q[$];
    int    mismatches;
    int    send_idle;
    int    recv_idle;
    bit    hold_off;
    bit    done_sending;
    row_t  directed[$];

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic plan_t plan_search(plan_req_t r);
        plan_t       p;
        longint      rows, cols, thr, ebits, max_vf, vf, tn, tm, vn, eff_rows, vm, eff;
        longint      b_tm, b_tn, b_vm, b_vn, b_eff;
        bit          async_ok, pred, b_pred, have, better;
        logic [2:0]  atom;
        p = '0;
        rows = r.box_rows;
        cols = r.box_cols;
        thr = r.thread_count;
        ebits = 8 << r.elem_size_code;
        max_vf = 128 / ebits;
        async_ok = r.to_shared && (thr % 32 == 0);
        if (thr < 2 || rows < 1 || cols < 1 || rows > tcls_pkg::EXTENT_MAX
            || cols > tcls_pkg::EXTENT_MAX)
            return p;
        for (vf = max_vf; vf >= 1; vf = vf / 2)
        begin
            have = 0;
            b_pred = 0;
            b_tm = 0; b_tn = 0; b_vm = 0; b_vn = 0; b_eff = 0;
            if (cols % vf != 0)
                continue;
            for (tn = 1; tn <= thr && tn * vf <= cols; tn = tn * 2)
            begin
                if (thr % tn != 0 || cols % tn != 0)
                    continue;
                tm = thr / tn;
                vn = cols / tn;
                if (vn % vf != 0)
                    continue;
                pred = 0;
                eff_rows = rows;
                if (rows % tm != 0)
                begin
                    pred = 1;
                    eff_rows = ((rows + tm - 1) / tm) * tm;
                end
                vm = max_vf / vn;
                if (vm < 1)
                    vm = 1;
                while (vm > 1 && eff_rows % (tm * vm) != 0)
                    vm = vm / 2;
                if (eff_rows % (tm * vm) != 0)
                    continue;
                eff = vn * ebits;
                if (vf * ebits < eff)
                    eff = vf * ebits;
                if (eff > 128)
                    eff = 128;
                better = !have || (!pred && b_pred) || (pred == b_pred && eff > b_eff) ||
                         (pred == b_pred && eff == b_eff && tn > b_tn);
                if (better)
                begin
                    b_tm = tm; b_tn = tn; b_vm = vm; b_vn = vn;
                    b_pred = pred; b_eff = eff; have = 1;
                end
            end
            if (!have)
                continue;
            case (vf * ebits)
                128:     atom = async_ok ? tcls_pkg::ATOM_ASYNC_128 : tcls_pkg::ATOM_VEC_128;
                64:      atom = async_ok ? tcls_pkg::ATOM_ASYNC_64 : tcls_pkg::ATOM_VEC_64;
                32:      atom = async_ok ? tcls_pkg::ATOM_ASYNC_32 : tcls_pkg::ATOM_VEC_32;
                16:      atom = tcls_pkg::ATOM_VEC_16;
                default: atom = tcls_pkg::ATOM_UNIVERSAL;
            endcase
            p.found = 1'b1;
            p.thread_rows = b_tm[15:0];
            p.thread_cols = b_tn[15:0];
            p.value_rows = b_vm[4:0];
            p.value_cols = b_vn[15:0];
            p.atom_code = atom;
            p.need_predicate = b_pred;
            p.pred_rows = b_pred ? r.box_rows : 16'd0;
            p.pred_cols = b_pred ? r.box_cols : 16'd0;
            return p;
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic plan_req_t random_req();
        plan_req_t r;
        int        sel;
        sel = $urandom_range(0, 9);
        r.elem_size_code = 2'($urandom_range(0, 3));
        r.to_shared = 1'($urandom_range(0, 1));
        if (sel < 6)
        begin
            r.box_rows = 16'($urandom_range(1, 256));
            r.box_cols = 16'd1 << $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0)
                r.box_cols = 16'($urandom_range(1, 512));
            r.thread_count = 16'd1 << $urandom_range(1, 9);
            if ($urandom_range(0, 3) == 0)
                r.thread_count = 16'($urandom_range(2, 300));
        end
        else if (sel < 8)
        begin
            r.box_rows = 16'($urandom_range(0, 8));
            r.box_cols = 16'($urandom_range(0, 8));
            r.thread_count = 16'($urandom_range(0, 40));
        end
        else
        begin
            r.box_rows = 16'($urandom);
            r.box_cols = 16'($urandom);
            r.thread_count = 16'($urandom);
            if ($urandom_range(0, 1))
                r.thread_count = 16'(r.thread_count[10:0]);
        end
        return r;
    endfunction

    task automatic send(plan_req_t r);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        {req.box_rows, req.box_cols, req.thread_count, req.elem_size_code, req.to_shared} <= r;
        plan_q.push_back(plan_search(r));
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic add_row(logic [15:0] br, logic [15:0] bc, logic [15:0] tc, logic [1:0] es,
                           logic ts, logic known);
        row_t x;
        x.r = {br, bc, tc, es, ts};
        x.has_plan = known;
        x.p = '0;
        directed.push_back(x);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= !hold_off && !(recv_idle > 0 && $urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        plan_t got;
        plan_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.found, rsp.thread_rows, rsp.thread_cols, rsp.value_rows, rsp.value_cols,
                   rsp.atom_code, rsp.need_predicate, rsp.pred_rows, rsp.pred_cols};
            if (plan_q.size() == 0)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                want = plan_q.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.thread_rows !== want.thread_rows)
                    report_mismatch("thread_rows", got.thread_rows, want.thread_rows);
                if (got.thread_cols !== want.thread_cols)
                    report_mismatch("thread_cols", got.thread_cols, want.thread_cols);
                if (got.value_rows !== want.value_rows)
                    report_mismatch("value_rows", got.value_rows, want.value_rows);
                if (got.value_cols !== want.value_cols)
                    report_mismatch("value_cols", got.value_cols, want.value_cols);
                if (got.atom_code !== want.atom_code)
                    report_mismatch("atom_code", got.atom_code, want.atom_code);
                if (got.need_predicate !== want.need_predicate)
                    report_mismatch("need_predicate", got.need_predicate, want.need_predicate);
                if (got.pred_rows !== want.pred_rows)
                    report_mismatch("pred_rows", got.pred_rows, want.pred_rows);
                if (got.pred_cols !== want.pred_cols)
                    report_mismatch("pred_cols", got.pred_cols, want.pred_cols);
            end
        end
    end

    initial
    begin
        #80_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        hold_off = 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        plan_t p;
        mismatches = 0;
        send_idle = 0;
        recv_idle = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        {req.box_rows, req.box_cols, req.thread_count, req.elem_size_code, req.to_shared} = '0;
        // invalid and no-plan requests: every field zero
        add_row(16'd0, 16'd64, 16'd32, 2'd0, 1'b1, 1'b1);
        add_row(16'd64, 16'd0, 16'd32, 2'd1, 1'b0, 1'b1);
        add_row(16'd64, 16'd64, 16'd0, 2'd2, 1'b1, 1'b1);
        add_row(16'd64, 16'd64, 16'd1, 2'd3, 1'b0, 1'b1);
        add_row(16'd0, 16'd0, 16'd0, 2'd0, 1'b0, 1'b1);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1, 1'b0);
        add_row(16'hFFFF, 16'd128, 16'd32, 2'd0, 1'b1, 1'b0);
        add_row(16'd1, 16'd1, 16'd2, 2'd0, 1'b0, 1'b0);
        add_row(16'd64, 16'd64, 16'd32, 2'd0, 1'b1, 1'b0);
        add_row(16'd64, 16'd64, 16'd32, 2'd1, 1'b1, 1'b0);
        add_row(16'd64, 16'd64, 16'd32, 2'd2, 1'b1, 1'b0);
        add_row(16'd64, 16'd64, 16'd32, 2'd3, 1'b1, 1'b0);
        add_row(16'd64, 16'd64, 16'd32, 2'd0, 1'b0, 1'b0);
        add_row(16'd64, 16'd2, 16'd16, 2'd1, 1'b0, 1'b0);
        add_row(16'd64, 16'd3, 16'd16, 2'd0, 1'b0, 1'b0);
        add_row(16'd17, 16'd128, 16'd64, 2'd1, 1'b1, 1'b0);
        add_row(16'd5, 16'd32, 16'd96, 2'd2, 1'b1, 1'b0);
        add_row(16'd33, 16'd48, 16'd6, 2'd0, 1'b0, 1'b0);
        add_row(16'd128, 16'hFFFE, 16'h8000, 2'd1, 1'b1, 1'b0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            p = plan_search(directed[i].r);
            if (directed[i].has_plan && p !== directed[i].p)
                report_mismatch("planner on table row", i, 0);
            send(directed[i].r);
        end
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 36 : (phase == 1) ? 65 : 0;
            recv_idle = (phase == 0) ? 65 : (phase == 1) ? 36 : 0;
            repeat (380) send(random_req());
        end
        req.valid <= 1'b0;
        while (plan_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: tiled_copy_layout_search_top.f
rtl/core/tcls_pkg.sv
rtl/core/tcls_if.sv
rtl/core/tcls_div.sv
rtl/core/tcls_datapath.sv
rtl/core/tcls_ctrl.sv
rtl/core/tiled_copy_layout_search_top.sv
rtl/core/tcls_check.sv
sim/tcls_tb_if.sv
sim/tiled_copy_layout_search_top_test.sv
